FILE: rtl/dvld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dvld_pkg;

	// widths of the item fields
	localparam int unsigned NODE_ID_W    = 32;
	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned ID_WIDTH_DEF = 32;

	// varint coding constants
	localparam int unsigned GROUP_BITS   = 7;
	localparam int unsigned CONT_BIT     = 7;
	localparam logic [6:0]  PAYLOAD_MASK = 7'h7F;
	localparam logic [2:0]  GROUP_LIMIT  = 3'd5;

	// one coded byte of a neighbor list
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_list;
	} in_item_t;

	// one decoded neighbor id
	typedef struct packed {
		logic [NODE_ID_W-1:0] node_id;
		logic                 last_of_list;
	} out_item_t;

	// decoder status seen by the top level
	typedef struct packed {
		logic       take;
		logic       emit;
		logic       eol;
		logic       first;
		logic [2:0] group;
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/dvld_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module dvld_in_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_valid,
	output logic                   byte_ready,
	input  wire dvld_pkg::in_item_t byte_item,
	input  wire logic              take,
	output logic                   valid_s1,
	output dvld_pkg::in_item_t     item_s1
);

	// stage is free when empty or being drained this cycle
	assign byte_ready = !valid_s1 || take;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_item;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/dvld_core.sv
`timescale 1ns / 1ps
`default_nettype none

module dvld_core #(
	parameter int unsigned ID_WIDTH = dvld_pkg::ID_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               valid_s1,
	input  wire dvld_pkg::in_item_t item_s1,
	output logic                    take,
	output logic                    id_valid,
	input  wire logic               id_ready,
	output dvld_pkg::out_item_t     id_item,
	output dvld_pkg::status_t       status
);

	localparam int unsigned WIDE_W = dvld_pkg::NODE_ID_W + dvld_pkg::GROUP_BITS;

	logic [ID_WIDTH-1:0] acc_q;
	logic [ID_WIDTH-1:0] prev_q;
	logic [2:0]          grp_q;
	logic                first_q;
	logic                out_valid_q;
	dvld_pkg::out_item_t out_q;

	logic [5:0]          shamt;
	logic [WIDE_W-1:0]   part_wide;
	logic [ID_WIDTH-1:0] acc_new;
	logic [ID_WIDTH-1:0] value;
	logic                cont;
	logic                eol;
	logic                ends;
	logic                emit;
	logic                out_free;
	logic                grp_open;

	// shift of the current seven-bit group: 8*g - g
	assign shamt     = ({3'b000, grp_q} << 3) - {3'b000, grp_q};
	assign grp_open  = grp_q < dvld_pkg::GROUP_LIMIT;
	assign part_wide = {{(WIDE_W-7){1'b0}},
		item_s1.data_byte[6:0] & dvld_pkg::PAYLOAD_MASK} << shamt;
	assign acc_new   = grp_open ? (acc_q | part_wide[ID_WIDTH-1:0]) : acc_q;

	// varint end and id reconstruction
	assign cont  = item_s1.data_byte[dvld_pkg::CONT_BIT];
	assign eol   = item_s1.end_of_list;
	assign ends  = !cont || eol;
	assign value = first_q ? acc_new : (prev_q + acc_new);

	// handshake toward the result register
	assign out_free = !out_valid_q || id_ready;
	assign emit     = valid_s1 && ends;
	assign take     = valid_s1 && (!ends || out_free);

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			prev_q  <= '0;
			grp_q   <= '0;
			first_q <= 1'b1;
		end else if (take) begin
			if (!ends) begin
				acc_q <= acc_new;
				if (grp_open) begin
					grp_q <= grp_q + 3'd1;
				end
			end else if (eol) begin
				acc_q   <= '0;
				prev_q  <= '0;
				grp_q   <= '0;
				first_q <= 1'b1;
			end else begin
				acc_q   <= '0;
				prev_q  <= value;
				grp_q   <= '0;
				first_q <= 1'b0;
			end
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			out_q.node_id      <= dvld_pkg::NODE_ID_W'(value);
			out_q.last_of_list <= eol;
		end
	end

	assign id_valid = out_valid_q;
	assign id_item  = out_q;

	assign status.take  = take;
	assign status.emit  = emit;
	assign status.eol   = eol;
	assign status.first = first_q;
	assign status.group = grp_q;

endmodule

`default_nettype wire

FILE: rtl/delta_varint_list_decoder.sv
// Delta-coded base-128 varint neighbor list decoder.
// byte channel (byte_valid/byte_ready/byte_item): one coded byte per item,
//   bit 7 continuation, bits 6..0 payload, plus an end_of_list flag.
// id channel (id_valid/id_ready/id_item): one decoded absolute node id per
//   finished varint, with last_of_list set on the list's final id.
// A varint ends at a byte with the continuation bit clear, or at the list's
// final byte; the first id of a list is taken as is, later ones add to the
// previous id modulo 2^ID_WIDTH. Payload bits beyond ID_WIDTH are dropped.
// An id's final byte lands in the input register; the id is loaded into the
// result register when the core takes that byte.
// Throughput: one byte per cycle while no finishing byte is held; the per-byte
// shift, OR and add sit between the input register and the result register.
// Reset clears the accumulator, group count and previous id, and empties both
// registers. End of list does the same to the decode state.
// When id_ready is low a pending id is held; bytes that do not finish a
// varint keep flowing, and a finishing byte waits in the input register.
`timescale 1ns / 1ps
`default_nettype none

module delta_varint_list_decoder #(
	parameter int unsigned ID_WIDTH = dvld_pkg::ID_WIDTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_valid,
	output logic                     byte_ready,
	input  wire dvld_pkg::in_item_t  byte_item,
	output logic                     id_valid,
	input  wire logic                id_ready,
	output dvld_pkg::out_item_t      id_item
);

	logic               valid_s1;
	dvld_pkg::in_item_t item_s1;
	logic               take;
	dvld_pkg::status_t  status;

	// input register
	dvld_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.take       (take),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	// decode and result register
	dvld_core #(
		.ID_WIDTH (ID_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take     (take),
		.id_valid (id_valid),
		.id_ready (id_ready),
		.id_item  (id_item),
		.status   (status)
	);

	// group count never passes its limit
	a_group_limit: assert property (@(posedge clk) disable iff (!arst_n)
		status.group <= dvld_pkg::GROUP_LIMIT)
		else $error("group count beyond limit");

	// a finished varint always shows up at the output next cycle
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		status.take && status.emit |=> id_valid)
		else $error("finished varint not presented");

	// end of list restores the first-id state
	a_eol_clears: assert property (@(posedge clk) disable iff (!arst_n)
		status.take && status.emit && status.eol |=> status.first && status.group == 3'd0)
		else $error("end of list did not clear state");

	// a finishing byte only waits on a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		status.emit && !status.take |-> id_valid && !id_ready)
		else $error("finishing item held without output stall");

endmodule

`default_nettype wire

FILE: bench/delta_varint_list_decoder_tb.sv
`timescale 1ns / 1ps

module delta_varint_list_decoder_tb;

	localparam int unsigned ID_W       = dvld_pkg::ID_WIDTH_DEF;
	localparam logic [63:0] ID_MASK    = (64'd1 << ID_W) - 64'd1;
	localparam int          DIR_ROWS   = 24;
	localparam int          RAND_BYTES = 700;
	localparam logic        TYPED      = 1'b1;
	localparam logic        CALC       = 1'b0;

	// directed row: coded byte, end flag, whether the id is written out, id, last flag
	typedef struct packed {
		logic [7:0]  data;
		logic        eol;
		logic        typed;
		logic [31:0] node;
		logic        last;
	} dir_row_t;

	// typed expectation attached to each byte item
	typedef struct packed {
		logic                typed;
		dvld_pkg::out_item_t id;
	} want_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                byte_valid = 1'b0;
	logic                byte_ready;
	dvld_pkg::in_item_t  byte_item  = '0;
	logic                id_valid;
	logic                id_ready   = 1'b0;
	dvld_pkg::out_item_t id_item;

	// decoder state mirror
	logic [31:0] acc_bits      = '0;
	logic [2:0]  group_cnt     = '0;
	logic [31:0] prev_node     = '0;
	logic        first_pending = 1'b1;

	dvld_pkg::in_item_t  byte_q [$];
	want_t               want_q [$];
	dvld_pkg::out_item_t ids_due [$];
	int        errors     = 0;
	int        stall_left = 0;
	logic [8:0] rx_cycle  = '0;

	// sorted-list walk: zero, growth, long varint with saturation, wrap,
	// truncated ends, all-ones id, multi-byte deltas
	dir_row_t dir_rows [DIR_ROWS] = '{
		{8'h00, 1'b0, TYPED, 32'd0,          1'b0},
		{8'h7F, 1'b0, TYPED, 32'd127,        1'b0},
		{8'hFF, 1'b0, CALC,  32'd0,          1'b0},
		{8'hFF, 1'b0, CALC,  32'd0,          1'b0},
		{8'hFF, 1'b0, CALC,  32'd0,          1'b0},
		{8'hFF, 1'b0, CALC,  32'd0,          1'b0},
		{8'hFF, 1'b0, CALC,  32'd0,          1'b0},
		{8'hFF, 1'b0, CALC,  32'd0,          1'b0},
		{8'h00, 1'b0, TYPED, 32'd126,        1'b0},
		{8'h81, 1'b1, TYPED, 32'd127,        1'b1},
		{8'h80, 1'b1, TYPED, 32'd0,          1'b1},
		{8'hFF, 1'b0, CALC,  32'd0,          1'b0},
		{8'hFF, 1'b0, CALC,  32'd0,          1'b0},
		{8'hFF, 1'b0, CALC,  32'd0,          1'b0},
		{8'hFF, 1'b0, CALC,  32'd0,          1'b0},
		{8'h0F, 1'b1, TYPED, 32'hFFFF_FFFF,  1'b1},
		{8'h85, 1'b0, CALC,  32'd0,          1'b0},
		{8'h03, 1'b0, CALC,  32'd0,          1'b0},
		{8'h0A, 1'b0, CALC,  32'd0,          1'b0},
		{8'h00, 1'b1, CALC,  32'd0,          1'b0},
		{8'h01, 1'b1, TYPED, 32'd1,          1'b1},
		{8'hFF, 1'b0, CALC,  32'd0,          1'b0},
		{8'h7F, 1'b0, CALC,  32'd0,          1'b0},
		{8'h01, 1'b1, CALC,  32'd0,          1'b0}
	};

	delta_varint_list_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.id_valid   (id_valid),
		.id_ready   (id_ready),
		.id_item    (id_item)
	);

	always #1 clk = ~clk;

	// one coded byte into the decoder mirror, zero or one id out
	task automatic decode_byte(input dvld_pkg::in_item_t b, output logic has_id,
		output dvld_pkg::out_item_t id);
		logic [63:0] part;
		logic [31:0] sum;
		has_id = 1'b0;
		id = '0;
		if (group_cnt < dvld_pkg::GROUP_LIMIT) begin
			part = 64'(b.data_byte[6:0] & dvld_pkg::PAYLOAD_MASK)
				<< (dvld_pkg::GROUP_BITS * group_cnt);
			acc_bits = (acc_bits | part[31:0]) & ID_MASK[31:0];
		end
		if (b.data_byte[dvld_pkg::CONT_BIT] && !b.end_of_list) begin
			if (group_cnt < dvld_pkg::GROUP_LIMIT)
				group_cnt = group_cnt + 3'd1;
		end else begin
			sum = first_pending ? acc_bits : (prev_node + acc_bits) & ID_MASK[31:0];
			has_id = 1'b1;
			id.node_id = sum;
			id.last_of_list = b.end_of_list;
			// end of list drops everything back to the reset state
			if (b.end_of_list) begin
				prev_node = '0;
				first_pending = 1'b1;
			end else begin
				prev_node = sum;
				first_pending = 1'b0;
			end
			acc_bits = '0;
			group_cnt = '0;
		end
	endtask

	task automatic add_byte(input logic [7:0] b, input logic eol, input want_t w);
		dvld_pkg::in_item_t item;
		item = {b, eol};
		byte_q = {byte_q, item};
		want_q = {want_q, w};
	endtask

	// mostly well-formed lists with random payloads, some noise and truncation
	task automatic build_random();
		int n_ids;
		int len;
		int roll;
		int last_i;
		while (byte_q.size() < DIR_ROWS + RAND_BYTES) begin
			roll = $urandom_range(0, 99);
			if (roll < 10) begin
				len = $urandom_range(1, 12);
				repeat (len) add_byte(8'($urandom), $urandom_range(0, 7) == 0, '0);
			end else begin
				n_ids = (roll < 15) ? $urandom_range(20, 40) : $urandom_range(1, 8);
				repeat (n_ids) begin
					roll = $urandom_range(0, 99);
					len = (roll < 70) ? $urandom_range(1, 3) :
						(roll < 92) ? $urandom_range(4, 5) : $urandom_range(6, 8);
					for (int j = 0; j < len; j++)
						add_byte({j != len - 1, 7'($urandom)}, 1'b0, '0);
				end
				// close the list, sometimes on a byte that still says continue
				last_i = byte_q.size() - 1;
				byte_q[last_i].end_of_list = 1'b1;
				if ($urandom_range(0, 6) == 0)
					byte_q[last_i].data_byte[dvld_pkg::CONT_BIT] = 1'b1;
			end
		end
	endtask

	task automatic note_mismatch(input string what, input dvld_pkg::out_item_t exp_id,
		input dvld_pkg::out_item_t got_id);
		if (errors < 10)
			$display("%s: expected id %h last %b, got id %h last %b", what,
				exp_id.node_id, exp_id.last_of_list, got_id.node_id, got_id.last_of_list);
		errors++;
	endtask

	// sender: bursts of items with random gaps
	initial begin
		int burst_left;
		int gap;
		logic has_id;
		dvld_pkg::out_item_t pred;
		want_t w;
		foreach (dir_rows[i])
			add_byte(dir_rows[i].data, dir_rows[i].eol,
				{dir_rows[i].typed, dir_rows[i].node, dir_rows[i].last});
		build_random();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = 0;
		foreach (byte_q[i]) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = $urandom_range(0, 6);
				if (gap != 0) begin
					byte_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			byte_valid <= 1'b1;
			byte_item <= byte_q[i];
			@(posedge clk);
			while (!byte_ready) @(posedge clk);
			// item taken at this edge
			decode_byte(byte_q[i], has_id, pred);
			w = want_q[i];
			if (has_id)
				ids_due = {ids_due, (w.typed ? w.id : pred)};
		end
		byte_valid <= 1'b0;
		while (ids_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// receiver: starts stalls only while rx_cycle[8] is set, in alternate windows
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 9'd1;
		if (stall_left != 0) begin
			id_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (rx_cycle[8] && $urandom_range(0, 4) == 0) begin
			id_ready <= 1'b0;
			stall_left <= $urandom_range(0, 10);
		end else begin
			id_ready <= 1'b1;
		end
	end

	// id checker
	always @(posedge clk) begin
		dvld_pkg::out_item_t exp_id;
		if (arst_n && id_valid && id_ready) begin
			if (ids_due.size() == 0) begin
				note_mismatch("unexpected id", '0, id_item);
			end else begin
				exp_id = ids_due.pop_front();
				if (id_item.node_id !== exp_id.node_id ||
					id_item.last_of_list !== exp_id.last_of_list)
					note_mismatch("id mismatch", exp_id, id_item);
			end
		end
	end

	// watchdog
	initial begin
		#400_000;
		$display("tb: failure");
		$finish;
	end

endmodule
